// ===== sv/ebq_pkg.sv =====
// ----------------------------------------------------------------------------
// ebq_pkg
// Shared types, constants and helper functions of the encoder and button
// event qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ebq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   localparam int POS_W   = 32;
   localparam int TIME_W  = 48;
   localparam int DEB_W   = 20;
   localparam int LONG_W  = 24;
   localparam int BURST_W = 7;
   localparam int CODE_W  = 3;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 2;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [BURST_W-1:0] count_type;
   typedef logic [CODE_W-1:0]  code_type;

   localparam code_type EV_NONE  = 3'd0;
   localparam code_type EV_RIGHT = 3'd1;
   localparam code_type EV_LEFT  = 3'd2;
   localparam code_type EV_CLICK = 3'd3;
   localparam code_type EV_LONG  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BURST  = 2'd2;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = 20'd20000;
   localparam logic [LONG_W-1:0]  LONG_PRESS_RESET = 24'd1000000;
   localparam logic [BURST_W-1:0] MAX_BURST_RESET  = 7'd16;

   typedef struct packed {
      logic capture;
      logic calc;
      logic clamp;
      logic push_rot;
      logic btn;
      logic pop_rd;
      logic load_out;
      logic have_event;
   } ebq_cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic rot_pending;
      logic slot_free;
   } ebq_status_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // True when at least thr microseconds lie between start and now.
   function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] start,
                                    input logic [LONG_W-1:0] thr);
      logic [TIME_W:0] d;
      d = {1'b0, now} - {1'b0, start};
      return !d[TIME_W] && (d[TIME_W-1:0] >= {{(TIME_W-LONG_W){1'b0}}, thr});
   endfunction

endpackage

`default_nettype wire

// ===== sv/ebq_ram.sv =====
// ----------------------------------------------------------------------------
// ebq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ebq_datapath.sv =====
// ----------------------------------------------------------------------------
// ebq_datapath
// Request capture, rotation and button qualification, event ring and
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [ebq_pkg::POS_W-1:0]  req_position,
   input  wire logic                          req_position_valid,
   input  wire logic                          req_pressed,
   input  wire logic                          req_button_valid,
   input  wire logic [ebq_pkg::TIME_W-1:0]    req_now_us,
   input  wire logic                          csr_write,
   input  wire logic [ebq_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ebq_pkg::CSR_W-1:0]     csr_wdata,
   input  wire ebq_pkg::ebq_cmd_type          cmd,
   output ebq_pkg::ebq_status_type            status,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ebq_pkg::CODE_W-1:0]         rsp_event_code
);

   import ebq_pkg::*;

   logic [DEB_W-1:0]   debounce_ff;
   logic [LONG_W-1:0]  long_press_ff;
   logic [BURST_W-1:0] max_burst_ff;

   logic [POS_W-1:0]  pos_ff;
   logic              pos_valid_ff;
   logic              pressed_ff;
   logic              btn_valid_ff;
   logic [TIME_W-1:0] now_ff;

   logic [POS_W-1:0]  last_pos_ff;
   logic              last_pressed_ff;
   logic [TIME_W-1:0] last_change_ff;
   logic [TIME_W-1:0] press_start_ff;
   logic              long_fired_ff;

   logic [POS_W-1:0] diff_ff;
   logic             deb_ok_ff;
   logic             long_ok_ff;
   count_type        count_ff;
   logic             dir_left_ff;

   ptr_type  head_ff;
   ptr_type  tail_ff;
   ptr_type  head_in;
   ptr_type  tail_in;

   logic     rsp_valid_ff;
   code_type rsp_code_ff;

   logic [POS_W-1:0] mag;
   count_type        count_in;
   logic             btn_push;
   code_type         btn_code;
   logic             push_en;
   code_type         push_code;
   code_type         rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         max_burst_ff  <= MAX_BURST_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata[DEB_W-1:0];
            CSR_LONG_PRESS: long_press_ff <= csr_wdata[LONG_W-1:0];
            CSR_MAX_BURST:  max_burst_ff  <= csr_wdata[BURST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff       <= req_position;
         pos_valid_ff <= req_position_valid;
         pressed_ff   <= req_pressed;
         btn_valid_ff <= req_button_valid;
         now_ff       <= req_now_us;
      end
      if (cmd.calc) begin
         diff_ff    <= pos_ff - last_pos_ff;
         deb_ok_ff  <= elapsed(now_ff, last_change_ff, {{(LONG_W-DEB_W){1'b0}}, debounce_ff});
         long_ok_ff <= elapsed(now_ff, press_start_ff, long_press_ff);
      end
      if (cmd.clamp) begin
         dir_left_ff <= diff_ff[POS_W-1];
      end
   end

   always_comb begin
      mag = diff_ff[POS_W-1] ? (POS_W'(0) - diff_ff) : diff_ff;
      if (!pos_valid_ff) begin
         count_in = '0;
      end else if (mag > {{(POS_W-BURST_W){1'b0}}, max_burst_ff}) begin
         count_in = max_burst_ff;
      end else begin
         count_in = mag[BURST_W-1:0];
      end
   end

   always_comb begin
      btn_push = 1'b0;
      btn_code = EV_CLICK;
      if (btn_valid_ff) begin
         if (pressed_ff != last_pressed_ff) begin
            btn_push = deb_ok_ff && !pressed_ff && !long_fired_ff;
         end else if (pressed_ff && !long_fired_ff && long_ok_ff) begin
            btn_push = 1'b1;
            btn_code = EV_LONG;
         end
      end
   end

   assign push_en   = cmd.push_rot || (cmd.btn && btn_push);
   assign push_code = cmd.push_rot ? (dir_left_ff ? EV_LEFT : EV_RIGHT) : btn_code;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (push_en) begin
         head_in = ptr_next(head_ff);
         if (ptr_next(head_ff) == tail_ff) begin
            tail_in = ptr_next(tail_ff);
         end
      end else if (cmd.pop_rd) begin
         tail_in = ptr_next(tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff     <= '0;
         last_pressed_ff <= 1'b0;
         last_change_ff  <= '0;
         press_start_ff  <= '0;
         long_fired_ff   <= 1'b0;
         count_ff        <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (cmd.clamp) begin
            count_ff <= count_in;
            if (pos_valid_ff) begin
               last_pos_ff <= pos_ff;
            end
         end else if (cmd.push_rot) begin
            count_ff <= count_ff - BURST_W'(1);
         end
         if (cmd.btn && btn_valid_ff) begin
            if (pressed_ff != last_pressed_ff) begin
               if (deb_ok_ff) begin
                  if (pressed_ff) begin
                     press_start_ff <= now_ff;
                     long_fired_ff  <= 1'b0;
                  end
                  last_pressed_ff <= pressed_ff;
                  last_change_ff  <= now_ff;
               end
            end else if (pressed_ff && !long_fired_ff && long_ok_ff) begin
               long_fired_ff <= 1'b1;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_code_ff <= cmd.have_event ? rd_data : EV_NONE;
      end
   end

   ebq_ram #(
      .WIDTH(CODE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (push_en),
      .wr_addr(head_ff),
      .wr_data(push_code),
      .rd_en  (cmd.pop_rd),
      .rd_addr(tail_ff),
      .rd_data(rd_data)
   );

   assign status.ring_empty  = (head_ff == tail_ff);
   assign status.rot_pending = (count_ff != '0);
   assign status.slot_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> (head_ff != tail_ff))
      else $error("Ring read issued while the ring is empty.");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("Response overwritten before it was taken.");

   a_push_one_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push_rot && cmd.btn) && !(push_en && cmd.pop_rd))
      else $error("Ring push collides with another ring access.");

   a_long_fired_rose: assert property (@(posedge clock) disable iff (reset)
      $rose(long_fired_ff) |-> $past(push_en && (push_code == EV_LONG)))
      else $error("Long press marked without pushing its event.");

endmodule

`default_nettype wire

// ===== sv/ebq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebq_ctrl
// Sequencer: ring check, then a pop of a waiting event, or rotation pushes,
// button qualification and final pop; response load ends either path.
// ----------------------------------------------------------------------------
`default_nettype none

module ebq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ebq_pkg::ebq_status_type status,
   output ebq_pkg::ebq_cmd_type         cmd
);

   import ebq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_CALC,
      S_CLAMP,
      S_ROT,
      S_BTN,
      S_POP,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      have_event_ff;
   logic      have_event_in;

   always_comb begin
      state_in      = state_ff;
      have_event_in = have_event_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (!status.ring_empty) begin
               cmd.pop_rd    = 1'b1;
               have_event_in = 1'b1;
               state_in      = S_OUT;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_ROT;
         end
         S_ROT: begin
            if (status.rot_pending) begin
               cmd.push_rot = 1'b1;
            end else begin
               state_in = S_BTN;
            end
         end
         S_BTN: begin
            cmd.btn  = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            cmd.pop_rd    = !status.ring_empty;
            have_event_in = !status.ring_empty;
            state_in      = S_OUT;
         end
         S_OUT: begin
            cmd.have_event = have_event_ff;
            if (status.slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_event_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_event_ff <= have_event_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// ===== sv/encoder_button_event_qualifier.sv =====
// ----------------------------------------------------------------------------
// encoder_button_event_qualifier
// Turns encoder and button poll samples into a queue of user input events.
// ----------------------------------------------------------------------------
// Each request is one poll sample and returns exactly one response. When the
// event ring already holds events, the block pops the oldest one at once and
// loads it into the response register, and it returns to idle as it loads
// the response. Otherwise the block pushes the clamped rotation steps,
// qualifies the button, and pops one event if the ring holds one (else the
// response is EV_NONE). The ring RAM takes one push per cycle while rotation
// steps go in, and the block returns to idle as it loads the response. A
// response that is not taken holds the block in its last step until
// the previous response leaves. A new request is accepted while the previous
// response still waits to be taken.
`default_nettype none

module encoder_button_event_qualifier (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [ebq_pkg::POS_W-1:0]  req_position,
   input  wire logic                              req_position_valid,
   input  wire logic                              req_pressed,
   input  wire logic                              req_button_valid,
   input  wire logic [ebq_pkg::TIME_W-1:0]        req_now_us,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ebq_pkg::CODE_W-1:0]             rsp_event_code,
   input  wire logic                              csr_write,
   input  wire logic [ebq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ebq_pkg::CSR_W-1:0]         csr_wdata
);

   import ebq_pkg::*;

   ebq_cmd_type    cmd;
   ebq_status_type status;

   ebq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   ebq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_position      (req_position),
      .req_position_valid(req_position_valid),
      .req_pressed       (req_pressed),
      .req_button_valid  (req_button_valid),
      .req_now_us        (req_now_us),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_code    (rsp_event_code)
   );

endmodule

`default_nettype wire
